// File: rtl/lfs_pkg.sv
`timescale 1ns / 1ps

package lfs_pkg;

  localparam int MAX_SEGMENTS_DEFAULT = 128;
  localparam logic [7:0] SEG_MARK = 8'h08;
  localparam logic [8:0] LIMIT_RESET = 9'd256;
  localparam logic [8:0] LIMIT_MIN = 9'd3;
  localparam logic [8:0] LIMIT_MAX = 9'd256;
  localparam int NUM_W = 17;

  localparam logic [1:0] EMIT_MARK  = 2'd0;
  localparam logic [1:0] EMIT_COUNT = 2'd1;
  localparam logic [1:0] EMIT_DATA  = 2'd2;
  localparam logic [1:0] EMIT_ERROR = 2'd3;

  typedef struct packed {
    logic       load;
    logic       first_init;
    logic       div_step;
    logic       drop_step;
    logic       seg_start;
    logic       emit;
    logic [1:0] emit_sel;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic msg_empty;
    logic dropping;
    logic total_ge_lim;
    logic too_long;
    logic div_last;
    logic seg_needed;
    logic out_free;
  } status_t;

endpackage

// File: rtl/lfs_ctrl.sv
`timescale 1ns / 1ps

module lfs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  lfs_pkg::status_t status,
  output lfs_pkg::cmd_t   cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EVAL = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_SEG  = 3'd3;
  localparam logic [2:0] ST_HDR0 = 3'd4;
  localparam logic [2:0] ST_HDR1 = 3'd5;
  localparam logic [2:0] ST_DATA = 3'd6;
  localparam logic [2:0] ST_ERR  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (status.first) begin
          cmd.first_init = 1'b1;
          if (!status.total_ge_lim) begin
            state_next = ST_SEG;
          end else if (status.too_long) begin
            state_next = ST_ERR;
          end else begin
            state_next = ST_DIV;
          end
        end else if (status.msg_empty) begin
          state_next = ST_IDLE;
        end else if (status.dropping) begin
          cmd.drop_step = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_SEG;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_SEG;
        end
      end
      ST_SEG: begin
        if (status.seg_needed) begin
          cmd.seg_start = 1'b1;
          state_next = ST_HDR0;
        end else begin
          state_next = ST_DATA;
        end
      end
      ST_HDR0: begin
        cmd.emit_sel = lfs_pkg::EMIT_MARK;
        if (status.out_free) begin
          cmd.emit = 1'b1;
          state_next = ST_HDR1;
        end
      end
      ST_HDR1: begin
        cmd.emit_sel = lfs_pkg::EMIT_COUNT;
        if (status.out_free) begin
          cmd.emit = 1'b1;
          state_next = ST_DATA;
        end
      end
      ST_DATA: begin
        cmd.emit_sel = lfs_pkg::EMIT_DATA;
        if (status.out_free) begin
          cmd.emit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_ERR: begin
        cmd.emit_sel = lfs_pkg::EMIT_ERROR;
        if (status.out_free) begin
          cmd.emit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/lfs_datapath.sv
`timescale 1ns / 1ps

module lfs_datapath #(
  parameter int MAX_SEGMENTS = lfs_pkg::MAX_SEGMENTS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  input  logic [8:0]       cfg_data,
  input  logic [23:0]      s_tdata,
  input  logic [1:0]       s_tuser,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,
  output logic             m_tlast,
  output logic [2:0]       m_tuser,
  input  lfs_pkg::cmd_t    cmd,
  output lfs_pkg::status_t status
);

  localparam int NUM_W = lfs_pkg::NUM_W;
  localparam int Q_W = $clog2(MAX_SEGMENTS + 1);
  localparam int SW = $clog2(Q_W);
  localparam int SEG_W = $clog2(MAX_SEGMENTS);

  logic [8:0]       limit_reg;
  logic [8:0]       lim;
  logic [7:0]       seg_size;
  logic [NUM_W-1:0] max_bytes;

  logic [7:0]       db_q;
  logic [15:0]      len_q;
  logic             fb_q;
  logic             ud_q;
  logic [15:0]      total;

  logic [15:0]      msg_left;
  logic [7:0]       seg_left;
  logic [SEG_W-1:0] seg_to_come;
  logic             first_seg;
  logic             segmenting;
  logic             dropping;
  logic             kind;

  logic [NUM_W-1:0] rem;
  logic [Q_W-1:0]   quo;
  logic [SW-1:0]    step;
  logic [NUM_W-1:0] trial;
  logic             fits;
  logic [Q_W-1:0]   quo_next;

  logic             msg_last;
  logic             frm_last;
  logic             start_drop;

  always_comb begin
    if (limit_reg < lfs_pkg::LIMIT_MIN) begin
      lim = lfs_pkg::LIMIT_MIN;
    end else if (limit_reg > lfs_pkg::LIMIT_MAX) begin
      lim = lfs_pkg::LIMIT_MAX;
    end else begin
      lim = limit_reg;
    end
  end

  assign seg_size  = 8'(lim - 9'd2);
  assign max_bytes = NUM_W'(seg_size) * NUM_W'(MAX_SEGMENTS);
  assign total     = (len_q == 16'd0) ? 16'd1 : len_q;

  assign trial    = NUM_W'(seg_size) << step;
  assign fits     = (rem >= trial);
  assign quo_next = quo | (Q_W'(fits) << step);

  assign msg_last = (msg_left == 16'd1);
  assign frm_last = segmenting ? (seg_left == 8'd1) : msg_last;

  assign start_drop = status.total_ge_lim && status.too_long;

  assign status.first        = fb_q;
  assign status.msg_empty    = (msg_left == 16'd0);
  assign status.dropping     = dropping;
  assign status.total_ge_lim = ({7'd0, lim} <= total);
  assign status.too_long     = ({1'b0, total} > max_bytes);
  assign status.div_last     = (step == SW'(0));
  assign status.seg_needed   = segmenting && (seg_left == 8'd0);
  assign status.out_free     = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_reg <= lfs_pkg::LIMIT_RESET;
    end else if (cfg_valid) begin
      limit_reg <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      db_q  <= s_tdata[7:0];
      len_q <= s_tdata[23:8];
      fb_q  <= s_tuser[0];
      ud_q  <= s_tuser[1];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.first_init) begin
      rem  <= NUM_W'(total) + NUM_W'(seg_size) - NUM_W'(1);
      quo  <= '0;
      step <= SW'(Q_W - 1);
    end else if (cmd.div_step) begin
      if (fits) begin
        rem <= rem - trial;
      end
      quo <= quo_next;
      if (step != SW'(0)) begin
        step <= step - SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      msg_left    <= '0;
      seg_left    <= '0;
      seg_to_come <= '0;
      first_seg   <= 1'b1;
      segmenting  <= 1'b0;
      dropping    <= 1'b0;
      kind        <= 1'b0;
    end else if (cmd.first_init) begin
      kind        <= ud_q;
      seg_left    <= '0;
      seg_to_come <= '0;
      first_seg   <= 1'b1;
      segmenting  <= status.total_ge_lim && !status.too_long;
      dropping    <= start_drop && (total != 16'd1);
      msg_left    <= start_drop ? (total - 16'd1) : total;
    end else if (cmd.div_step) begin
      if (status.div_last) begin
        seg_to_come <= SEG_W'(quo_next - Q_W'(1));
      end
    end else if (cmd.drop_step) begin
      msg_left <= msg_left - 16'd1;
      if (msg_last) begin
        dropping <= 1'b0;
      end
    end else if (cmd.seg_start) begin
      seg_left <= (msg_left < {8'd0, seg_size}) ? msg_left[7:0] : seg_size;
    end else if (cmd.emit) begin
      if (cmd.emit_sel == lfs_pkg::EMIT_COUNT) begin
        first_seg <= 1'b0;
        if (seg_to_come != '0) begin
          seg_to_come <= seg_to_come - SEG_W'(1);
        end
      end else if (cmd.emit_sel == lfs_pkg::EMIT_DATA) begin
        msg_left <= msg_left - 16'd1;
        if (msg_last) begin
          segmenting  <= 1'b0;
          seg_left    <= '0;
          seg_to_come <= '0;
          first_seg   <= 1'b1;
        end else if (segmenting) begin
          seg_left <= seg_left - 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tuser[1] <= kind;
      unique case (cmd.emit_sel)
        lfs_pkg::EMIT_MARK: begin
          m_tdata    <= lfs_pkg::SEG_MARK;
          m_tlast    <= 1'b0;
          m_tuser[0] <= 1'b0;
          m_tuser[2] <= 1'b0;
        end
        lfs_pkg::EMIT_COUNT: begin
          m_tdata    <= {first_seg, 7'(seg_to_come)};
          m_tlast    <= 1'b0;
          m_tuser[0] <= 1'b0;
          m_tuser[2] <= 1'b0;
        end
        lfs_pkg::EMIT_DATA: begin
          m_tdata    <= db_q;
          m_tlast    <= frm_last;
          m_tuser[0] <= msg_last;
          m_tuser[2] <= 1'b0;
        end
        lfs_pkg::EMIT_ERROR: begin
          m_tdata    <= 8'd0;
          m_tlast    <= 1'b0;
          m_tuser[0] <= 1'b0;
          m_tuser[2] <= 1'b1;
        end
        default: begin
          m_tdata    <= 8'd0;
          m_tlast    <= 1'b0;
          m_tuser[0] <= 1'b0;
          m_tuser[2] <= 1'b0;
        end
      endcase
    end
  end

endmodule

// File: rtl/link_frame_segmenter_unit.sv
`timescale 1ns / 1ps

// Channel  Direction  Beat contents
// s_*      in         tdata: data_byte, msg_length; tuser: first_byte, unit_data
// m_*      out        tdata: out_byte; tlast: frame_last;
//                     tuser: message_last, out_unit_data, too_long
// cfg_*    in         cfg_data: max_info_length
//
// An input beat passes the states IDLE and EVAL, then SEG and DATA when it yields one
// data beat, SEG, HDR0, HDR1 and DATA when a segment starts and two header beats go
// first, ERR when it yields the error beat, and no further state when it yields nothing.
// The first beat of a segmented message also passes the DIV state, where a restoring
// divider yields one segment-count quotient bit per cycle (8 bits for 128 segments).
// Reset is synchronous; it clears the controller and the message state and sets the limit
// to 256.
// A stalled output holds the controller in its emit state; no input is taken then.

module link_frame_segmenter_unit #(
  parameter int MAX_SEGMENTS = lfs_pkg::MAX_SEGMENTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // data_byte, msg_length
  input  logic [1:0]  s_tuser,   // first_byte, unit_data
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte
  output logic        m_tlast,
  output logic [2:0]  m_tuser,   // message_last, out_unit_data, too_long
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data
);

  lfs_pkg::cmd_t    cmd;
  lfs_pkg::status_t status;

  assign cfg_ready = 1'b1;

  lfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lfs_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// File: tb/link_frame_segmenter_unit_tb.sv
`timescale 1ns / 1ps

module link_frame_segmenter_unit_tb;

  localparam int MAX_SEG = lfs_pkg::MAX_SEGMENTS_DEFAULT;
  localparam int SETTLE_CYCLES = 32;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_PHASES = 9;
  localparam int BYTES_PER_PHASE = 32;

  typedef struct packed {
    logic [7:0] data;
    logic       frame_last;
    logic       message_last;
    logic       unit_data;
    logic       too_long;
  } frame_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic [2:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [8:0]  cfg_data = '0;

  // Segmenter state as the predictor sees it.
  logic [8:0]  limit_reg;
  int          msg_left;
  int          seg_left;
  logic [6:0]  segs_to_come;
  logic        first_seg;
  logic        seg_mode;
  logic        drop_mode;
  logic        kind_q;

  frame_beat_t pending_frame_beats[$];
  int          mismatches = 0;
  int          accepted_bytes = 0;
  int          rx_stall = 0;
  bit          tx_gap_en = 1'b1;
  bit          rx_gap_en = 1'b1;
  bit          rx_hold = 1'b0;
  bit          hold_go = 1'b0;

  link_frame_segmenter_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int effective_limit();
    if (limit_reg < lfs_pkg::LIMIT_MIN) return int'(lfs_pkg::LIMIT_MIN);
    if (limit_reg > lfs_pkg::LIMIT_MAX) return int'(lfs_pkg::LIMIT_MAX);
    return int'(limit_reg);
  endfunction

  function automatic void reset_segmenter_state();
    limit_reg = lfs_pkg::LIMIT_RESET;
    msg_left = 0;
    seg_left = 0;
    segs_to_come = '0;
    first_seg = 1'b1;
    seg_mode = 1'b0;
    drop_mode = 1'b0;
    kind_q = 1'b0;
  endfunction

  function automatic void queue_frame_beat(logic [7:0] b, logic fl, logic ml, logic tl);
    pending_frame_beats.push_back('{b, fl, ml, kind_q, tl});
  endfunction

  function automatic void segment_message_byte(logic [7:0] data, logic [15:0] len,
                                               logic first, logic unit);
    int lim;
    int total;
    int seg_data;
    int nseg;
    logic last_msg;
    logic last_frame;
    if (first) begin
      lim = effective_limit();
      total = (len == 16'd0) ? 1 : int'(len);
      kind_q = unit;
      seg_mode = 1'b0;
      drop_mode = 1'b0;
      seg_left = 0;
      segs_to_come = '0;
      first_seg = 1'b1;
      msg_left = total;
      if (total >= lim) begin
        seg_data = lim - 2;
        nseg = (total + seg_data - 1) / seg_data;
        if (nseg > MAX_SEG) begin
          msg_left = total - 1;
          drop_mode = (msg_left != 0);
          queue_frame_beat(8'h00, 1'b0, 1'b0, 1'b1);
          return;
        end
        seg_mode = 1'b1;
        segs_to_come = 7'(nseg - 1);
      end
    end else if (msg_left == 0) begin
      return;
    end
    if (drop_mode) begin
      msg_left--;
      if (msg_left == 0) drop_mode = 1'b0;
      return;
    end
    if (seg_mode && seg_left == 0) begin
      seg_data = effective_limit() - 2;
      seg_left = (msg_left < seg_data) ? msg_left : seg_data;
      queue_frame_beat(lfs_pkg::SEG_MARK, 1'b0, 1'b0, 1'b0);
      queue_frame_beat({first_seg, segs_to_come}, 1'b0, 1'b0, 1'b0);
      first_seg = 1'b0;
      if (segs_to_come != 0) segs_to_come--;
    end
    msg_left--;
    last_msg = (msg_left == 0);
    if (seg_mode) begin
      seg_left--;
      last_frame = (seg_left == 0);
    end else begin
      last_frame = last_msg;
    end
    queue_frame_beat(data, last_frame, last_msg, 1'b0);
    if (last_msg) begin
      seg_mode = 1'b0;
      seg_left = 0;
      segs_to_come = '0;
      first_seg = 1'b1;
    end
  endfunction

  // Output side: checks every beat and, when rx gaps are enabled, stalls at random after each one.
  always @(posedge clk) begin
    frame_beat_t got;
    frame_beat_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = '{m_tdata, m_tlast, m_tuser[0], m_tuser[1], m_tuser[2]};
        if (pending_frame_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected beat: data %h tlast %b msg_last %b unit %b too_long %b",
                     got.data, got.frame_last, got.message_last, got.unit_data,
                     got.too_long);
        end else begin
          want = pending_frame_beats.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("beat mismatch: expected %h/%b/%b/%b/%b got %h/%b/%b/%b/%b",
                       want.data, want.frame_last, want.message_last, want.unit_data,
                       want.too_long, got.data, got.frame_last, got.message_last,
                       got.unit_data, got.too_long);
          end
        end
        if (rx_gap_en) rx_stall = $urandom_range(0, 15);
      end
      if (rx_stall > 0) begin
        rx_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !rx_hold;
      end
    end
  end

  // Long output hold-off, counted here so the sender keeps pushing meanwhile.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_go) begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
        hold_go = 1'b0;
      end
    end
  end

  task automatic send_beat(input logic [7:0] data, input logic [15:0] len,
                           input logic first, input logic unit);
    int gap;
    int queued;
    gap = tx_gap_en ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {len, data};
    s_tuser <= {unit, first};
    do @(posedge clk); while (!s_tready);
    queued = pending_frame_beats.size();
    segment_message_byte(data, len, first, unit);
    if (pending_frame_beats.size() != queued) accepted_bytes++;
  endtask

  task automatic send_body(input int count);
    repeat (count) send_beat(8'($urandom), 16'($urandom), 1'b0, 1'($urandom));
  endtask

  task automatic send_message(input logic [15:0] len_field, input int count);
    send_beat(8'($urandom), len_field, 1'b1, 1'($urandom));
    send_body(count - 1);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_frame_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [8:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    limit_reg = value;
  endtask

  function automatic int pick_length(int lim);
    int d;
    int r;
    int len;
    d = lim - 2;
    r = $urandom_range(0, 3);
    len = $urandom_range(1, 12);
    if (r == 1 && lim <= 48) begin
      len = lim + $urandom_range(0, 2) - 1;
    end else if (r == 2) begin
      len = d * $urandom_range(2, 6) + $urandom_range(0, 2) - 1;
      if (len > 60) len = $urandom_range(1, 12);
    end else if (r == 3) begin
      len = $urandom_range(1, 40);
    end
    return len;
  endfunction

  task automatic test_pass_through();
    send_beat(8'h00, 16'd1, 1'b1, 1'b0);
    send_beat(8'hFF, 16'd1, 1'b1, 1'b1);
    send_beat(8'h5A, 16'd0, 1'b1, 1'b0);
    send_beat(8'h33, 16'hFFFF, 1'b0, 1'b1);
    send_beat(8'h01, 16'd3, 1'b1, 1'b1);
    send_beat(8'h02, 16'd0, 1'b0, 1'b0);
    send_beat(8'h03, 16'h8000, 1'b0, 1'b0);
    send_beat(8'h10, 16'd5, 1'b1, 1'b0);
    send_beat(8'h11, 16'd0, 1'b0, 1'b0);
    send_beat(8'h12, 16'd1, 1'b1, 1'b1);
    // A message far past the segment limit is flagged, dropped, then abandoned.
    send_beat(8'hC3, 16'hFFFF, 1'b1, 1'b1);
    send_beat(8'h44, 16'd7, 1'b0, 1'b0);
    send_beat(8'h7E, 16'd2, 1'b1, 1'b0);
    send_beat(8'h81, 16'hFFFF, 1'b0, 1'b1);
    settle();
  endtask

  task automatic test_segment_headers();
    write_limit(9'd5);
    send_message(16'd7, 7);
    send_message(16'd5, 5);
    send_message(16'd4, 4);
    settle();
  endtask

  task automatic test_limit_change_mid_message();
    write_limit(9'd10);
    send_message(16'd20, 8);
    // The smaller size takes over at the next segment and the count bottoms out.
    write_limit(9'd3);
    send_body(12);
    settle();
  endtask

  task automatic test_segment_count_bounds();
    write_limit(9'd0);
    // Both messages are abandoned early by the next first byte.
    send_message(16'(MAX_SEG), 4);
    send_message(16'(MAX_SEG + 1), 3);
    send_message(16'd2, 2);
    settle();
  endtask

  task automatic test_full_frame_limit();
    write_limit(9'd511);
    send_message(16'd256, 4);
    settle();
  endtask

  task automatic test_output_backpressure();
    write_limit(9'd8);
    tx_gap_en = 1'b0;
    rx_gap_en = 1'b0;
    hold_go = 1'b1;
    send_message(16'd30, 30);
    settle();
    tx_gap_en = 1'b1;
    rx_gap_en = 1'b1;
  endtask

  task automatic send_random_message();
    int d;
    int kind;
    int len;
    d = effective_limit() - 2;
    kind = $urandom_range(0, 19);
    if (kind < 2) begin
      if (msg_left == 0) begin
        repeat ($urandom_range(1, 3)) begin
          send_beat(8'($urandom), 16'($urandom), 1'b0, 1'($urandom));
        end
      end
    end else if (kind < 4) begin
      send_message(16'($urandom_range(MAX_SEG * d + 1, 65535)), $urandom_range(1, 4));
    end else if (kind == 4) begin
      send_message(16'd0, 1);
    end else begin
      len = pick_length(effective_limit());
      send_message(16'(len), (kind < 7) ? $urandom_range(1, len) : len);
    end
  endtask

  task automatic test_random_traffic();
    logic [8:0] limits [RANDOM_PHASES];
    int target;
    int mode;
    limits = '{9'd256, 9'd3, 9'd4, 9'd6, 9'd10, 9'd17, 9'd40, 9'd130, 9'd3};
    limits[RANDOM_PHASES - 1] = 9'($urandom_range(3, 256));
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_limit(limits[p]);
      mode = (p == 0) ? 0 : (p == 1) ? 3 : $urandom_range(0, 3);
      tx_gap_en = mode[0];
      rx_gap_en = mode[1];
      target = accepted_bytes + BYTES_PER_PHASE;
      while (accepted_bytes < target) send_random_message();
    end
    settle();
  endtask

  initial begin
    reset_segmenter_state();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_pass_through();
    test_segment_headers();
    test_limit_change_mid_message();
    test_segment_count_bounds();
    test_full_frame_limit();
    test_output_backpressure();
    test_random_traffic();
    settle();
    if (mismatches == 0 && pending_frame_beats.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
